>>> design/cltok_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Config line tokeniser package
// Shared constants, character codes, token classes and the structs passed
// between the line tokeniser core, the result queue and the top level.
// ----------------------------------------------------------------------------
package cltok_pkg;

   // Column limit; columns saturate here
   localparam int LINE_LEN    = 1024;
   localparam int COL_W       = 11;
   localparam int CHAR_W      = 8;

   // At most three results per character: closed token, token closed at
   // line end, end-of-line marker
   localparam int MAX_RESULTS = 3;

   // Result queue; depth must be a power of two
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(LINE_LEN);

   // Character codes
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;

   typedef enum logic [2:0] {
      CLS_SPACE   = 3'd0,
      CLS_NUMBER  = 3'd1,
      CLS_COMPARE = 3'd2,
      CLS_DELIM   = 3'd3,
      CLS_NAME    = 3'd4,
      CLS_STRING  = 3'd5,
      CLS_NONE    = 3'd7
   } class_type;

   typedef enum logic {
      KIND_TOKEN = 1'b0,
      KIND_EOL   = 1'b1
   } kind_type;

   typedef struct packed {
      class_type               prev_class;
      logic                    token_open;
      logic [COL_W-1:0]        column;
      logic [COL_W-1:0]        token_start;
      logic [CHAR_W-1:0]       last_char;
      logic                    in_comment;
      logic                    overflowed;
   } line_state_type;

   localparam line_state_type LINE_RESET = '{
      prev_class:  CLS_NONE,
      token_open:  1'b0,
      column:      '0,
      token_start: '0,
      last_char:   '0,
      in_comment:  1'b0,
      overflowed:  1'b0
   };

   typedef struct packed {
      kind_type                kind;
      class_type               token_class;
      logic [COL_W-1:0]        start_col;
      logic [COL_W-1:0]        end_col;
      logic                    too_long;
   } result_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0]  valid;
      result_type [MAX_RESULTS-1:0] item;
   } result_set_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0]   level;
      logic                    room;
   } fifo_status_type;

   // Sort one character into its class
   function automatic class_type classify(input logic [CHAR_W-1:0] c);
      class_type cls;
      if (c == CH_SPACE || c == CH_TAB)
         cls = CLS_SPACE;
      else if (c == CH_DOLLAR || (c >= CH_ZERO && c <= CH_NINE))
         cls = CLS_NUMBER;
      else if (c == CH_LT || c == CH_EQ || c == CH_GT || c == CH_BANG)
         cls = CLS_COMPARE;
      else if (c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN || c == CH_COLON)
         cls = CLS_DELIM;
      else if (c == CH_DQUOTE || c == CH_SQUOTE)
         cls = CLS_STRING;
      else
         cls = CLS_NAME;
      return cls;
   endfunction

   function automatic logic is_hex_letter(input logic [CHAR_W-1:0] c);
      return (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

endpackage
`default_nettype wire

>>> design/cltok_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line tokeniser core
// Per-character classification and token boundary logic: from the current
// line state and one character, work out the next state and up to three
// results, in order.
// ----------------------------------------------------------------------------
module cltok_core
   import cltok_pkg::*;
(
   input  logic [CHAR_W-1:0] ch,
   input  logic              line_end,
   input  line_state_type    line_cur,
   output line_state_type    line_nxt,
   output result_set_type    results
);

   class_type          cls;
   logic [COL_W-1:0]   col_next;
   logic               ovf;
   logic               zero_x;
   logic               fresh;
   logic               tok_put;
   line_state_type     mid;
   result_type         tok_res;
   result_type         tail_res;
   result_type         eol_res;

   always_comb begin
      cls      = classify(ch);
      col_next = (line_cur.column < COL_LIMIT) ? (line_cur.column + COL_W'(1)) : COL_LIMIT;
      ovf      = line_cur.overflowed | (line_cur.column >= COL_LIMIT);
      // '0x' prefix: an 'x' right after a one-character '0' number
      zero_x   = (ch == CH_X) && (line_cur.last_char == CH_ZERO) &&
                 (({1'b0, line_cur.token_start} + (COL_W+1)'(1)) ==
                  {1'b0, line_cur.column});

      mid            = line_cur;
      mid.overflowed = ovf;
      mid.last_char  = ch;
      mid.column     = col_next;

      fresh   = 1'b0;
      tok_put = 1'b0;
      tok_res = '{kind: KIND_TOKEN, token_class: line_cur.prev_class,
                  start_col: line_cur.token_start, end_col: line_cur.column,
                  too_long: ovf};

      if (!line_cur.in_comment) begin
         if (line_cur.prev_class != CLS_STRING && ch == CH_SEMI) begin
            // Comment mark: close the open token, drop the rest of the line
            tok_put        = line_cur.token_open;
            mid.token_open = 1'b0;
            mid.in_comment = 1'b1;
         end else begin
            case (line_cur.prev_class)
               CLS_SPACE: begin
                  fresh = (cls != CLS_SPACE);
               end
               CLS_NUMBER: begin
                  if (ch == CH_DOLLAR)
                     fresh = 1'b1;
                  else if (zero_x || is_hex_letter(ch))
                     fresh = 1'b0;
                  else
                     fresh = (cls != CLS_NUMBER);
               end
               CLS_COMPARE: begin
                  fresh = (cls != CLS_COMPARE);
               end
               CLS_DELIM: begin
                  fresh = 1'b1;
               end
               CLS_NAME: begin
                  if (cls == CLS_NUMBER)
                     fresh = (ch == CH_DOLLAR);
                  else
                     fresh = (cls != CLS_NAME);
               end
               CLS_STRING: begin
                  if (line_cur.token_open) begin
                     // Closing quote ends the string just past itself
                     if (cls == CLS_STRING) begin
                        tok_put         = 1'b1;
                        tok_res.end_col = col_next;
                        mid.token_open  = 1'b0;
                     end
                  end else begin
                     fresh = 1'b1;
                  end
               end
               default: begin
                  // Start of line: leading whitespace opens a space token
                  if (cls == CLS_SPACE) begin
                     mid.token_start = line_cur.column;
                     mid.token_open  = 1'b1;
                     mid.prev_class  = CLS_SPACE;
                  end else begin
                     fresh = 1'b1;
                  end
               end
            endcase

            // New class: close the open token, open the next unless a space
            if (fresh) begin
               tok_put        = line_cur.token_open;
               mid.token_open = 1'b0;
               mid.prev_class = cls;
               if (cls != CLS_SPACE) begin
                  mid.token_start = line_cur.column;
                  mid.token_open  = 1'b1;
               end
            end
         end
      end

      tail_res = '{kind: KIND_TOKEN, token_class: mid.prev_class,
                   start_col: mid.token_start, end_col: col_next, too_long: ovf};
      eol_res  = '{kind: KIND_EOL, token_class: CLS_SPACE,
                   start_col: '0, end_col: col_next, too_long: ovf};

      results.valid   = {line_end, line_end & mid.token_open, tok_put};
      results.item[0] = tok_res;
      results.item[1] = tail_res;
      results.item[2] = eol_res;

      line_nxt = line_end ? LINE_RESET : mid;
   end

endmodule
`default_nettype wire

>>> design/cltok_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line tokeniser result queue
// Small register queue that takes up to three results in one cycle, packed
// in order, and hands them out one per cycle while pop_ready is high.
// ----------------------------------------------------------------------------
module cltok_fifo
   import cltok_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_en,
   input  result_set_type  push,
   output logic            pop_valid,
   input  logic            pop_ready,
   output result_type      head,
   output fifo_status_type status
);

   result_type [FIFO_DEPTH-1:0]       slot_ff, slot_in;
   logic [FIFO_PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]             level_ff, level_in;
   logic [FIFO_PTR_W-1:0]             wr_addr [MAX_RESULTS];
   logic [MAX_RESULTS-1:0]            wr_en;
   logic [FIFO_CNT_W-1:0]             offs;
   logic                              pop;

   // Pack valid results into consecutive slots
   always_comb begin
      offs = '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         wr_en[i]   = push_en & push.valid[i];
         wr_addr[i] = wr_ptr_ff + offs[FIFO_PTR_W-1:0];
         offs       = offs + FIFO_CNT_W'(wr_en[i]);
      end
   end

   // Place valid results in their slots
   always_comb begin
      slot_in = slot_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (wr_en[i]) begin
            slot_in[wr_addr[i]] = push.item[i];
         end
      end
   end

   assign pop       = pop_valid & pop_ready;
   assign pop_valid = (level_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign wr_ptr_in = wr_ptr_ff + offs[FIFO_PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign level_in  = level_ff + offs - FIFO_CNT_W'(pop);

   assign status.level = level_ff;
   assign status.room  = (level_ff <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store results
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule
`default_nettype wire

>>> design/config_line_tokenizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Config line tokeniser unit
// Splits a text line, streamed one character per request, into classified
// tokens with start and end columns, followed by an end-of-line marker.
// ----------------------------------------------------------------------------
// One character is taken per clock while the queue has room. Each character is
// classified and its token boundaries resolved combinationally against the
// registered line state, and its results (none, one, or up to three on the last
// character of a line) go into a four-entry result queue that drains one result
// per cycle while rsp_tready is high. A request is accepted whenever the queue
// has room for three results, so with rsp_tready high a stream that yields at
// most one result per character runs at one character per cycle even while a
// result waits; characters that yield several results hold the input for the
// extra drain cycles. Columns saturate at LINE_LEN and set too_long for the
// rest of the line. There is no configuration and no clearing pass after reset.
module config_line_tokenizer_unit
   import cltok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Character request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // line_end
   // Token results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [2:0] token_class, [13:3] start_col,
                                    // [24:14] end_col, [25] too_long, rest zero
   output logic        rsp_tuser    // kind
);

   line_state_type  line_ff, line_in;
   result_set_type  results;
   result_type      head;
   fifo_status_type fifo_stat;
   logic            accept;

   assign req_tready = fifo_stat.room;
   assign accept     = req_tvalid & req_tready;

   cltok_core u_core (
      .ch       (req_tdata),
      .line_end (req_tlast),
      .line_cur (line_ff),
      .line_nxt (line_in),
      .results  (results)
   );

   // Hold line state until a character is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= LINE_RESET;
      end else if (accept) begin
         line_ff <= line_in;
      end
   end

   cltok_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (results),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .head      (head),
      .status    (fifo_stat)
   );

   // Pack the result at the head of the queue
   assign rsp_tdata = {6'b0, head.too_long, head.end_col, head.start_col,
                       head.token_class};
   assign rsp_tuser = head.kind;

`ifndef NO_ASSERTIONS
   // The last character of a line returns the line state to its start
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=>
         (line_ff.column == '0 && !line_ff.token_open && !line_ff.in_comment))
      else $error("line state not cleared after line end");

   // No token stays open once a comment has started
   a_comment_closed: assert property (@(posedge clock) disable iff (reset)
      line_ff.in_comment |-> !line_ff.token_open)
      else $error("token open inside comment");

   // Queue never overfills
   a_fifo_level: assert property (@(posedge clock) disable iff (reset)
      fifo_stat.level <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // Column counter saturates at the limit
   a_column_sat: assert property (@(posedge clock) disable iff (reset)
      line_ff.column <= COL_LIMIT)
      else $error("column beyond limit");
`endif

endmodule
`default_nettype wire

>>> tb/config_line_tokenizer_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Config line tokeniser checker
// Watches the character and token channels of the tokeniser, predicts the
// token results of every accepted character and compares each accepted
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module config_line_tokenizer_unit_checker
   import cltok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // line_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [2:0] token_class, [13:3] start_col,
                                    // [24:14] end_col, [25] too_long, rest zero
   input  logic        rsp_tuser,   // kind
   output int          fail_count,
   output int          outstanding,
   output int          result_count,
   output int          line_count
);

   // Predicted line state
   class_type        cur_class;
   logic             tok_open;
   logic [COL_W-1:0] cur_col;
   logic [COL_W-1:0] tok_start;
   logic [7:0]       prev_char;
   logic             skip_rest;
   logic             col_saturated;

   result_type       expected_tokens[$];

   // Return the line state to its start-of-line value
   function automatic void restart_line();
      cur_class     = CLS_NONE;
      tok_open      = 1'b0;
      cur_col       = '0;
      tok_start     = '0;
      prev_char     = '0;
      skip_rest     = 1'b0;
      col_saturated = 1'b0;
   endfunction

   initial begin
      fail_count   = 0;
      outstanding  = 0;
      result_count = 0;
      line_count   = 0;
      restart_line();
   end

   function automatic class_type char_kind(input logic [7:0] c);
      case (c)
         CH_SPACE, CH_TAB:                      return CLS_SPACE;
         CH_DOLLAR:                             return CLS_NUMBER;
         CH_LT, CH_EQ, CH_GT, CH_BANG:          return CLS_COMPARE;
         CH_COMMA, CH_LPAREN, CH_RPAREN, CH_COLON: return CLS_DELIM;
         CH_DQUOTE, CH_SQUOTE:                  return CLS_STRING;
         default: begin
            if (c >= CH_ZERO && c <= CH_NINE)
               return CLS_NUMBER;
            return CLS_NAME;
         end
      endcase
   endfunction

   function automatic logic hex_letter(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
   endfunction

   function automatic void expect_token(input kind_type k, input class_type cls,
                                        input logic [COL_W-1:0] s,
                                        input logic [COL_W-1:0] e);
      result_type r;
      r.kind        = k;
      r.token_class = cls;
      r.start_col   = s;
      r.end_col     = e;
      r.too_long    = col_saturated;
      expected_tokens = {expected_tokens, r};
   endfunction

   // Work out the token results of one accepted character
   function automatic void predict_char(input logic [7:0] c, input logic eol);
      class_type        cls;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] nxt;
      logic             fresh;
      col   = cur_col;
      nxt   = (col < LINE_LEN) ? col + COL_W'(1) : COL_LIMIT;
      fresh = 1'b0;
      if (col >= LINE_LEN)
         col_saturated = 1'b1;

      if (!skip_rest) begin
         if (cur_class != CLS_STRING && c == CH_SEMI) begin
            // comment mark: close the open token here, ignore the rest
            if (tok_open)
               expect_token(KIND_TOKEN, cur_class, tok_start, col);
            tok_open  = 1'b0;
            skip_rest = 1'b1;
         end else begin
            cls = char_kind(c);
            case (cur_class)
               CLS_SPACE:   fresh = (cls != CLS_SPACE);
               CLS_NUMBER: begin
                  if (c == CH_DOLLAR)
                     fresh = 1'b1;
                  else if (c == CH_X && int'(tok_start) + 1 == int'(col) &&
                           prev_char == CH_ZERO)
                     fresh = 1'b0;
                  else if (hex_letter(c))
                     fresh = 1'b0;
                  else
                     fresh = (cls != CLS_NUMBER);
               end
               CLS_COMPARE: fresh = (cls != CLS_COMPARE);
               CLS_DELIM:   fresh = 1'b1;
               CLS_NAME: begin
                  if (cls == CLS_NUMBER)
                     fresh = (c == CH_DOLLAR);
                  else
                     fresh = (cls != CLS_NAME);
               end
               CLS_STRING: begin
                  if (tok_open) begin
                     // closing quote ends the string just past itself
                     if (cls == CLS_STRING) begin
                        expect_token(KIND_TOKEN, CLS_STRING, tok_start, nxt);
                        tok_open = 1'b0;
                     end
                  end else begin
                     fresh = 1'b1;
                  end
               end
               default: begin
                  // first character of the line
                  if (cls == CLS_SPACE) begin
                     tok_start = col;
                     tok_open  = 1'b1;
                     cur_class = CLS_SPACE;
                  end else begin
                     fresh = 1'b1;
                  end
               end
            endcase
            if (fresh) begin
               if (tok_open) begin
                  expect_token(KIND_TOKEN, cur_class, tok_start, col);
                  tok_open = 1'b0;
               end
               cur_class = cls;
               if (cls != CLS_SPACE) begin
                  tok_start = col;
                  tok_open  = 1'b1;
               end
            end
         end
      end

      prev_char = c;
      cur_col   = nxt;

      if (eol) begin
         if (tok_open)
            expect_token(KIND_TOKEN, cur_class, tok_start, nxt);
         expect_token(KIND_EOL, CLS_SPACE, '0, nxt);
         line_count++;
         restart_line();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH at %0t, result %0d, %s: expected 0x%0h, got 0x%0h",
               $realtime, result_count, what, want, got);
      fail_count++;
   endtask

   // Compare one accepted result with the oldest prediction
   task automatic check_result();
      result_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("unexpected result", 32'h0, rsp_tdata);
      end else begin
         want = expected_tokens.pop_front();
         if (rsp_tuser !== want.kind)
            report_mismatch("kind", 32'(want.kind), 32'(rsp_tuser));
         if (rsp_tdata[2:0] !== want.token_class)
            report_mismatch("token_class", 32'(want.token_class), 32'(rsp_tdata[2:0]));
         if (rsp_tdata[13:3] !== want.start_col)
            report_mismatch("start_col", 32'(want.start_col), 32'(rsp_tdata[13:3]));
         if (rsp_tdata[24:14] !== want.end_col)
            report_mismatch("end_col", 32'(want.end_col), 32'(rsp_tdata[24:14]));
         if (rsp_tdata[25] !== want.too_long)
            report_mismatch("too_long", 32'(want.too_long), 32'(rsp_tdata[25]));
         if (rsp_tdata[31:26] !== 6'd0)
            report_mismatch("padding", 32'h0, 32'(rsp_tdata[31:26]));
      end
      result_count++;
   endtask

   // Sample mid-cycle: the handshake seen here completes at the next rising edge
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            predict_char(req_tdata, req_tlast);
      end
      outstanding = expected_tokens.size();
   end

endmodule

>>> tb/config_line_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Config line tokeniser testbench
// Streams directed lines, two lines beyond the column limit and random lines
// of well-formed tokens mixed with noise bytes into the tokeniser, with random
// idle bursts on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module config_line_tokenizer_unit_tb;
   import cltok_pkg::*;

   localparam int RANDOM_ITEMS = 280;
   localparam int QUIET_ITEMS  = 60;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   int          fail_count;
   int          outstanding;
   int          result_count;
   int          line_count;

   int          chars_sent  = 0;
   int          cycle_count = 0;
   int          stall_left  = 0;
   bit          idle_on     = 1'b1;
   logic [7:0]  line_buf[$];

   config_line_tokenizer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   config_line_tokenizer_unit_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .result_count (result_count),
      .line_count   (line_count)
   );

   always #10 clock = ~clock;

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, outstanding);
         $display("config_line_tokenizer_unit_tb failed");
         $finish;
      end
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one character request and hold it until accepted
   task automatic send_char(input logic [7:0] c, input logic eol);
      bit taken;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eol;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      chars_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // Append one character to the line being built
   task automatic add_char(input logic [7:0] c);
      line_buf = {line_buf, c};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i]);
   endtask

   function automatic logic [7:0] hex_char();
      case ($urandom_range(0, 2))
         0:       return CH_ZERO + 8'($urandom_range(0, 9));
         1:       return CH_LO_A + 8'($urandom_range(0, 5));
         default: return CH_UP_A + 8'($urandom_range(0, 5));
      endcase
   endfunction

   // Append one random fragment: mostly well-formed tokens, some noise
   task automatic add_fragment();
      int n;
      n = $urandom_range(1, 4);
      case ($urandom_range(0, 10))
         0: repeat (n) add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         1, 2: begin
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: add_char(CH_LO_A + 8'($urandom_range(0, 25)));
                  1: add_char(CH_UP_A + 8'($urandom_range(0, 25)));
                  2: add_char(CH_ZERO + 8'($urandom_range(0, 9)));
                  default: add_char($urandom_range(0, 1) ? 8'h5F : 8'h2E);
               endcase
            end
         end
         3: repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
         4: begin
            add_char(CH_ZERO);
            add_char(CH_X);
            repeat (n) add_char(hex_char());
         end
         5: begin
            add_char(CH_DOLLAR);
            repeat (n - 1) add_char(hex_char());
         end
         6: begin
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0:       add_char(CH_LT);
                  1:       add_char(CH_EQ);
                  2:       add_char(CH_GT);
                  default: add_char(CH_BANG);
               endcase
            end
         end
         7: begin
            case ($urandom_range(0, 3))
               0:       add_char(CH_COMMA);
               1:       add_char(CH_LPAREN);
               2:       add_char(CH_RPAREN);
               default: add_char(CH_COLON);
            endcase
         end
         8: begin
            add_char($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            repeat (n - 1) add_char(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 4) != 0)
               add_char($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
         end
         9: begin
            add_char(CH_SEMI);
            repeat (n - 1) add_char(8'($urandom_range(0, 255)));
         end
         default: add_char(8'($urandom_range(0, 255)));
      endcase
      // separate tokens now and then
      if ($urandom_range(0, 2) == 0)
         add_char(CH_SPACE);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines: leading blanks, hex and dollar numbers, name digits,
      // comparison run, delimiters, string closed then ';', comment with ignored
      // byte, extreme bytes
      add_text("\t 0x1F$A");
      send_line();
      add_text("b9$<=,(");
      send_line();
      add_text("'x';'q");
      send_line();
      add_text("z;");
      add_char(8'hFF);
      send_line();
      add_char(8'h00);
      send_line();

      // Lines past the column limit; the tail crosses saturation
      while (line_buf.size() < 1018)
         add_fragment();
      add_text("  0x0xA 'q;r");
      send_line();
      while (line_buf.size() < 1040)
         add_fragment();
      send_line();

      // Random lines, with the final stretch free of idling
      for (int base = chars_sent; chars_sent < base + RANDOM_ITEMS; ) begin
         idle_on = (chars_sent < base + RANDOM_ITEMS - QUIET_ITEMS) &&
                   ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
         end else begin
            if ($urandom_range(0, 2) == 0)
               add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            repeat ($urandom_range(1, 6)) add_fragment();
         end
         send_line();
      end
      req_tvalid <= 1'b0;

      // Drain the remaining results, then watch for strays
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d characters in %0d lines, two beyond the column limit;",
               chars_sent, line_count);
      $display("checked %0d token and end-of-line results, %0d mismatches.",
               result_count, fail_count);
      if (fail_count == 0 && outstanding == 0)
         $display("config_line_tokenizer_unit_tb passed");
      else
         $display("config_line_tokenizer_unit_tb failed");
      $finish;
   end

endmodule
